FILE: sv/bfm_pkg.sv
// Shared types, constants and arithmetic helpers for the 2x2 box-filter mip chain.
// No dependencies; every other file in this folder imports this package.
`timescale 1ns / 1ps

package bfm_pkg;

   localparam int PIX_W        = 8;     // bits per color channel
   localparam int CHANNELS     = 4;     // red, green, blue, alpha
   localparam int SUM_W        = PIX_W + 1;
   localparam int POS_W        = 10;
   localparam int LEVEL_W      = 2;
   localparam int SIZE_W       = 9;
   localparam int MAX_SIDE_DEF = 1024;
   localparam int SIZE_RESET   = 16;
   localparam int RES_MAX      = 3;     // results one item can cause
   localparam int RES_CNT_W    = 2;

   typedef enum logic [LEVEL_W-1:0] {
      MIP_L0 = 2'd0,
      MIP_L1 = 2'd1,
      MIP_L2 = 2'd2
   } mip_level_type;

   typedef logic [CHANNELS-1:0][PIX_W-1:0] pixel_type;
   typedef logic [CHANNELS-1:0][SUM_W-1:0] pair_sum_type;

   typedef struct packed {
      mip_level_type          level;
      logic [POS_W-1:0]       pos_x;
      logic [POS_W-1:0]       pos_y;
      pixel_type              pix;
   } result_type;

   // Per-item control handed from the input register to a filter stage.
   typedef struct packed {
      logic advance;
      logic col_odd;
      logic row_odd;
   } stage_ctrl_type;

   // Rounded average of a stored pair sum and two fresh channel values.
   function automatic logic [PIX_W-1:0] box_avg(input logic [SUM_W-1:0] s,
                                                 input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      logic [SUM_W+1:0] t;
      t = (SUM_W+2)'(s) + (SUM_W+2)'(a) + (SUM_W+2)'(b) + (SUM_W+2)'(2);
      return t[PIX_W+1:2];
   endfunction

   function automatic logic [SUM_W-1:0] pair_add(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
      return SUM_W'(a) + SUM_W'(b);
   endfunction

endpackage

FILE: sv/bfm_stage.sv
// One 2x2 box-filter stage: previous-pixel register, line buffer of pair sums
// and the averaging logic. Depends on bfm_pkg.
`timescale 1ns / 1ps

module bfm_stage #(
   parameter int DEPTH = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   input  bfm_pkg::stage_ctrl_type        ctrl,
   input  bfm_pkg::pixel_type             cur_pix,
   output bfm_pkg::pixel_type             res_pix,
   output logic                           res_valid
);
   import bfm_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   pair_sum_type  mem [DEPTH];
   pair_sum_type  rd_data_ff;
   logic [AW-1:0] addr_ff;
   pixel_type     prev_ff;
   pixel_type     prev_in;
   pair_sum_type  wr_data;
   logic          wr_en;

   // The line buffer is read when the item is taken in, so the stored sum is
   // ready by the time the item sits in the input register.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         addr_ff    <= rd_addr;
      end
   end

   assign wr_en = ctrl.advance & ctrl.col_odd & ~ctrl.row_odd;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         wr_data[c] = pair_add(prev_ff[c], cur_pix[c]);
         res_pix[c] = box_avg(rd_data_ff[c], prev_ff[c], cur_pix[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= wr_data;
      end
   end

   assign prev_in   = (ctrl.advance & ~ctrl.col_odd) ? cur_pix : prev_ff;
   assign res_valid = ctrl.col_odd & ctrl.row_odd;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

FILE: sv/bfm_out_seq.sv
// Result register and sequencer: holds the one to three results of an item and
// hands them out one per accepted transfer. Depends on bfm_pkg.
`timescale 1ns / 1ps

module bfm_out_seq (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       load_valid,
   output logic                                       load_ready,
   input  bfm_pkg::result_type [bfm_pkg::RES_MAX-1:0] load_res,
   input  logic [bfm_pkg::RES_CNT_W-1:0]              load_count,
   input  logic                                       load_frame_end,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output bfm_pkg::result_type                        out_res,
   output logic                                       out_last,
   output logic                                       out_frame_end
);
   import bfm_pkg::*;

   result_type [RES_MAX-1:0] res_ff;
   logic [RES_CNT_W-1:0]     cnt_ff;
   logic [RES_CNT_W-1:0]     idx_ff;
   logic [RES_CNT_W-1:0]     idx_in;
   logic                     valid_ff;
   logic                     valid_in;
   logic                     fend_ff;
   logic                     out_fire;
   logic                     load;

   assign out_valid     = valid_ff;
   assign out_res       = res_ff[idx_ff];
   assign out_last      = (idx_ff == cnt_ff - RES_CNT_W'(1));
   assign out_frame_end = fend_ff;
   assign out_fire      = valid_ff & out_ready;
   assign load_ready    = ~valid_ff | (out_fire & out_last);
   assign load          = load_valid & load_ready;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = '0;
         valid_in = 1'b1;
      end else if (out_fire) begin
         idx_in   = idx_ff + RES_CNT_W'(1);
         valid_in = ~out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= load_res;
         cnt_ff  <= load_count;
         fend_ff <= load_frame_end;
      end
   end

endmodule

FILE: sv/box_filter_mip_chain_2x2_unit.sv
// Top level of the two-level 2x2 box-filter mip chain generator.
// Depends on bfm_pkg, bfm_stage and bfm_out_seq.
`timescale 1ns / 1ps

// Usage:
// Level-0 RGBA pixels enter on the req_ stream in raster order, one item per
// pixel, red in the lowest byte of req_tdata. The image is square with a side
// of four times csr_wdata as last written (0 acts as 1, values above
// MAX_SIDE / 4 act as MAX_SIDE / 4); any write restarts the frame at the top
// left corner. Write the register only while the block is idle.
// Every item yields its level-0 pass-through result. An item that closes a 2x2
// block also yields a level-1 average, and one that closes a 2x2 block of
// level-1 pixels yields a level-2 average as well, in that order. rsp_tlast
// marks the final result of each item; rsp_tuser carries the mip level and a
// frame-end flag set on every result of the image's last pixel.
// An accepted item passes through the input register and then the result
// register before its first result appears. The result port moves one result
// per cycle while rsp_tready is high; the input register accepts the next
// item while earlier results are still being drained. When the receiver stalls,
// the result register holds and the input register fills, after which
// req_tready drops. Reset clears the counters, the previous-pixel registers and
// all valid flags and sets the size to 16 quads; the line buffers need no
// clearing, since every entry is written on an even row before it is read.
module box_filter_mip_chain_2x2_unit #(
   parameter int MAX_SIDE = bfm_pkg::MAX_SIDE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // rsp_tdata: pos_x[9:0], pos_y[19:10], out_red[27:20], out_green[35:28],
   //            out_blue[43:36], out_alpha[51:44], zero fill[55:52]
   output logic [55:0]                rsp_tdata,
   output logic                       rsp_tlast,
   // rsp_tuser: mip_level[1:0], frame_end[2]
   output logic [2:0]                 rsp_tuser,
   input  logic                       csr_wen,
   input  logic [bfm_pkg::SIZE_W-1:0] csr_wdata
);
   import bfm_pkg::*;

   localparam int CNT_W      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int QCMP_W     = (SIDE_W > SIZE_W) ? SIDE_W : SIZE_W;
   localparam int RESET_SIDE = (SIZE_RESET * 4 > MAX_SIDE) ? MAX_SIDE : SIZE_RESET * 4;
   localparam int L1_DEPTH   = MAX_SIDE / 2;
   localparam int L2_DEPTH   = (MAX_SIDE / 4 > 0) ? MAX_SIDE / 4 : 1;
   localparam int L1_AW      = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1;
   localparam int L2_AW      = (L2_DEPTH > 1) ? $clog2(L2_DEPTH) : 1;
   localparam int PAD_W      = 56 - 2 * POS_W - CHANNELS * PIX_W;

   // Frame geometry and raster position of the next item.
   logic [CNT_W-1:0]  last_idx_ff;
   logic [CNT_W-1:0]  last_idx_in;
   logic [CNT_W-1:0]  col_ff;
   logic [CNT_W-1:0]  col_in;
   logic [CNT_W-1:0]  row_ff;
   logic [CNT_W-1:0]  row_in;
   logic [QCMP_W-1:0] quads;
   logic [QCMP_W-1:0] quads_cl;
   logic [SIDE_W-1:0] side_new;

   // Input register.
   logic              s1_valid_ff;
   logic              s1_valid_in;
   pixel_type         s1_pix_ff;
   logic [CNT_W-1:0]  s1_x_ff;
   logic [CNT_W-1:0]  s1_y_ff;
   logic              s1_fend_ff;

   logic              accept;
   logic              advance;
   logic              seq_ready;
   logic              frame_last;

   stage_ctrl_type    l1_ctrl;
   stage_ctrl_type    l2_ctrl;
   pixel_type         l1_pix;
   pixel_type         l2_pix;
   logic              l1_valid;
   logic              l1_hit;
   logic              l2_hit;

   result_type [RES_MAX-1:0] res_all;
   logic [RES_CNT_W-1:0]     res_count;
   result_type               out_res;
   logic                     out_fend;
   logic [LEVEL_W-1:0]       rsp_level;

   // ---------------------------------------------------------------------
   // Size register: the clamp is applied at write time and only the index of
   // the last column (equal to the last row) is kept.
   // ---------------------------------------------------------------------
   always_comb begin
      quads = QCMP_W'(csr_wdata);
      if (quads == '0) begin
         quads_cl = QCMP_W'(1);
      end else if (quads > QCMP_W'(MAX_SIDE / 4)) begin
         quads_cl = QCMP_W'(MAX_SIDE / 4);
      end else begin
         quads_cl = quads;
      end
      side_new    = SIDE_W'({quads_cl, 2'b00});
      last_idx_in = csr_wen ? CNT_W'(side_new - SIDE_W'(1)) : last_idx_ff;
   end

   assign req_tready = ~s1_valid_ff | seq_ready;
   assign accept     = req_tvalid & req_tready;
   assign advance    = s1_valid_ff & seq_ready;
   assign frame_last = (col_ff == last_idx_ff) & (row_ff == last_idx_ff);

   // Raster counters step on every accepted item and wrap at the frame end;
   // a size write sends them back to the top left corner.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wen) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == last_idx_ff) begin
            col_in = '0;
            row_in = (row_ff == last_idx_ff) ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff <= CNT_W'(RESET_SIDE - 1);
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         last_idx_ff <= last_idx_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register: holds one item until the result register can take all
   // of its results.
   // ---------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_tdata;
         s1_x_ff    <= col_ff;
         s1_y_ff    <= row_ff;
         s1_fend_ff <= frame_last;
      end
   end

   // ---------------------------------------------------------------------
   // Filter stages. Level 1 works on the level-0 coordinates, level 2 on the
   // level-1 coordinates, which are the level-0 ones shifted right by one.
   // Both line buffers are read at the address of the incoming item.
   // ---------------------------------------------------------------------
   assign l1_ctrl.advance = advance;
   assign l1_ctrl.col_odd = s1_x_ff[0];
   assign l1_ctrl.row_odd = s1_y_ff[0];

   bfm_stage #(
      .DEPTH (L1_DEPTH)
   ) u_stage_l1 (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (L1_AW'(col_ff >> 1)),
      .ctrl      (l1_ctrl),
      .cur_pix   (s1_pix_ff),
      .res_pix   (l1_pix),
      .res_valid (l1_valid)
   );

   // The level-2 stage only sees items that produced a level-1 pixel.
   assign l2_ctrl.advance = advance & l1_valid;
   assign l2_ctrl.col_odd = (CNT_W > 1) ? s1_x_ff[CNT_W > 1 ? 1 : 0] : 1'b0;
   assign l2_ctrl.row_odd = (CNT_W > 1) ? s1_y_ff[CNT_W > 1 ? 1 : 0] : 1'b0;

   bfm_stage #(
      .DEPTH (L2_DEPTH)
   ) u_stage_l2 (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (L2_AW'(col_ff >> 2)),
      .ctrl      (l2_ctrl),
      .cur_pix   (l1_pix),
      .res_pix   (l2_pix),
      .res_valid (l2_hit)
   );

   assign l1_hit = l1_valid;

   always_comb begin
      res_all[0].level = MIP_L0;
      res_all[0].pos_x = POS_W'(s1_x_ff);
      res_all[0].pos_y = POS_W'(s1_y_ff);
      res_all[0].pix   = s1_pix_ff;
      res_all[1].level = MIP_L1;
      res_all[1].pos_x = POS_W'(s1_x_ff >> 1);
      res_all[1].pos_y = POS_W'(s1_y_ff >> 1);
      res_all[1].pix   = l1_pix;
      res_all[2].level = MIP_L2;
      res_all[2].pos_x = POS_W'(s1_x_ff >> 2);
      res_all[2].pos_y = POS_W'(s1_y_ff >> 2);
      res_all[2].pix   = l2_pix;
      res_count        = RES_CNT_W'(1) + RES_CNT_W'(l1_hit) + RES_CNT_W'(l1_hit & l2_hit);
   end

   // ---------------------------------------------------------------------
   // Result register and output sequencing.
   // ---------------------------------------------------------------------
   bfm_out_seq u_out_seq (
      .clock          (clock),
      .reset          (reset),
      .load_valid     (s1_valid_ff),
      .load_ready     (seq_ready),
      .load_res       (res_all),
      .load_count     (res_count),
      .load_frame_end (s1_fend_ff),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_res        (out_res),
      .out_last       (rsp_tlast),
      .out_frame_end  (out_fend)
   );

   assign rsp_tdata = {PAD_W'(0), out_res.pix, out_res.pos_y, out_res.pos_x};
   assign rsp_level = out_res.level;
   assign rsp_tuser = {out_fend, rsp_level};

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // Within one item the levels come out in rising order without a gap.
   a_level_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_level == $past(rsp_level) + LEVEL_W'(1)))
      else $error("mip levels of one item out of order");

   // An item's first result is always the level-0 pass-through.
   a_first_is_l0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || rsp_level == MIP_L0)
      else $error("item did not start with a level-0 result");

   // The raster counters never leave the current frame.
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_idx_ff && row_ff <= last_idx_ff)
      else $error("raster counter beyond frame edge");

   // A level-2 result needs both the column and the row to close a 4x4 block.
   a_l2_position: assert property (@(posedge clock) disable iff (reset)
      advance && res_count == RES_CNT_W'(3) |->
         s1_x_ff[0] && s1_y_ff[0] && l2_ctrl.col_odd && l2_ctrl.row_odd)
      else $error("level-2 result at wrong position");

endmodule
